@@ hw/rtl/lsm_pkg.sv @@
// Shared types, constants and helper functions for the line substring matcher.
package lsm_pkg;

   localparam int PATTERN_MAX_DEF = 16;
   localparam int LINE_MAX_DEF    = 255;
   localparam int PAT_BYTES       = 16;
   localparam int PAT_LEN_W       = 5;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;
   localparam logic [7:0] COLON   = 8'h3A;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_LO     = 3'd0,
      CSR_PAT_HI     = 3'd1,
      CSR_PAT_LEN    = 3'd2,
      CSR_WHOLE_WORD = 3'd3,
      CSR_LABEL_MODE = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      SUF_IDLE = 4'b0001,
      SUF_SCAN = 4'b0010,
      SUF_PASS = 4'b0100,
      SUF_FAIL = 4'b1000
   } suffix_state_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
      logic [7:0] start_column;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] match_column;
   } rsp_type;

   // per-cell flags: compare and word class of the held byte and of the byte shifting in
   typedef struct packed {
      logic eq_hold;
      logic eq_shift;
      logic word_hold;
      logic word_shift;
   } cell_status_type;

   function automatic logic is_word(input logic [7:0] b);
      logic res;
      res = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h61 && b <= 8'h7A) || (b == 8'h2E);
      return res;
   endfunction

   function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] pat,
                                           input logic [7:0] idx);
      logic [7:0] res;
      res = 8'h00;
      if (idx < 8'(PAT_BYTES)) begin
         res = pat[{idx[3:0], 3'b000} +: 8];
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/lsm_cell.sv @@
// One window cell: holds a text byte, passes it to the next cell, compares it to a pattern byte.
module lsm_cell (
   input  logic                     clock,
   input  logic                     load,
   input  logic [7:0]               byte_in,
   input  logic [7:0]               pat_in,
   output logic [7:0]               byte_out,
   output lsm_pkg::cell_status_type status
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_sel;

   assign byte_in_sel = load ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_sel;
   end

   assign byte_out          = byte_ff;
   assign status.eq_hold    = (byte_ff == pat_in);
   assign status.eq_shift   = (byte_in == pat_in);
   assign status.word_hold  = lsm_pkg::is_word(byte_ff);
   assign status.word_shift = lsm_pkg::is_word(byte_in);

endmodule

@@ hw/rtl/line_substring_matcher.sv @@
// Top level of the line substring matcher: cell chain, match control and result register.
//
// Text bytes of a line enter on the req_ channel, one per accepted request; line_end
// marks the last byte and start_column is taken on the first byte of each line.
// Exactly one result leaves on the rsp_ channel per line, registered when the line's
// last byte is accepted: found and the first accepted match column.
// The pattern and mode registers are written through csr_we/csr_index/csr_wdata.
// Throughput: one byte per cycle unless stalled. A row of PATTERN_MAX+1 cells holds
// the most recent bytes; every byte shifts the row and all pattern offsets compare in
// parallel, so the candidate ending at each column is judged in the cycle its right
// neighbor arrives. Latency: the result is valid on the cycle after the last byte
// is accepted. Reset clears the column counter, match state, result valid and the
// registers to their defaults (pattern length 1, modes off). No clearing pass is
// needed. While a result is held under rsp_stall, bytes that do not end a line are
// still accepted; a line_end request is stalled until the result register frees up.
module line_substring_matcher #(
   parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF,
   parameter int LINE_MAX    = lsm_pkg::LINE_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lsm_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lsm_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [lsm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lsm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int Depth = PATTERN_MAX + 1;
   localparam int ColW  = $clog2(LINE_MAX + 3);
   localparam int LenW  = $clog2(PATTERN_MAX + 1);
   localparam int EW    = ((ColW > LenW) ? ColW : LenW) + 1;

   // configuration registers
   logic [63:0]                     pat_lo_ff, pat_hi_ff;
   logic [lsm_pkg::PAT_LEN_W-1:0]   pat_len_ff;
   logic                            whole_word_ff, label_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff     <= '0;
         pat_hi_ff     <= '0;
         pat_len_ff    <= lsm_pkg::PAT_LEN_W'(1);
         whole_word_ff <= 1'b0;
         label_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (lsm_pkg::csr_index_type'(csr_index))
            lsm_pkg::CSR_PAT_LO:     pat_lo_ff     <= csr_wdata;
            lsm_pkg::CSR_PAT_HI:     pat_hi_ff     <= csr_wdata;
            lsm_pkg::CSR_PAT_LEN:    pat_len_ff    <= csr_wdata[lsm_pkg::PAT_LEN_W-1:0];
            lsm_pkg::CSR_WHOLE_WORD: whole_word_ff <= csr_wdata[0];
            lsm_pkg::CSR_LABEL_MODE: label_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [127:0] pat;
   assign pat = {pat_hi_ff, pat_lo_ff};

   // effective pattern length: clamp, then drop a trailing colon in label mode
   logic [EW-1:0] len1, len2, len_e;
   logic [7:0]    tail_byte;

   always_comb begin
      len1 = (pat_len_ff == '0) ? EW'(1) : EW'(pat_len_ff);
      len2 = (len1 > EW'(PATTERN_MAX)) ? EW'(PATTERN_MAX) : len1;
      tail_byte = lsm_pkg::pat_byte(pat, 8'(len2 - EW'(1)));
      len_e = (label_mode_ff && tail_byte == lsm_pkg::COLON) ? len2 - EW'(1) : len2;
   end

   // line state
   logic [ColW-1:0]                col_ff, col_in;
   logic [7:0]                     start_ff, start_in;
   logic                           ms_ff, ms_in;
   logic [ColW-1:0]                mp_ff, mp_in;
   logic                           pre_ff, pre_in;
   lsm_pkg::suffix_state_type      suf_ff, suf_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   lsm_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic req_accept, first, last;

   assign req_stall  = rsp_valid_ff && rsp_stall && req_data.line_end;
   assign req_accept = req_valid && !req_stall;
   assign first      = (col_ff == '0);
   assign last       = req_data.line_end;

   // cell chain
   logic [7:0]                cell_byte [Depth];
   logic [7:0]                cell_in   [Depth];
   logic [7:0]                cell_pat  [Depth];
   lsm_pkg::cell_status_type  cell_st   [Depth];
   logic [Depth-1:0]          act_v, eqh_v, eqs_v, lefth_v, lefts_v, rng_v, wordh_v;
   logic [EW-1:0]             c_e;

   assign c_e = EW'(col_ff);

   for (genvar k = 0; k < Depth; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_in[k] = req_data.text_byte;
      end else begin : g_body
         // a new line starts from an all-zero window
         assign cell_in[k] = first ? 8'h00 : cell_byte[k-1];
      end

      assign cell_pat[k] = lsm_pkg::pat_byte(pat, 8'(len_e - EW'(k) - EW'(1)));

      lsm_cell u_cell (
         .clock    (clock),
         .load     (req_accept),
         .byte_in  (cell_in[k]),
         .pat_in   (cell_pat[k]),
         .byte_out (cell_byte[k]),
         .status   (cell_st[k])
      );

      assign act_v[k]   = (EW'(k) < len_e);
      assign eqh_v[k]   = cell_st[k].eq_hold;
      assign eqs_v[k]   = cell_st[k].eq_shift;
      assign wordh_v[k] = cell_st[k].word_hold;
      assign lefth_v[k] = (EW'(k) == len_e) && cell_st[k].word_hold;
      assign lefts_v[k] = (EW'(k) == len_e) && cell_st[k].word_shift;
      // label span: from the match start back to column 0, within the window
      assign rng_v[k]   = (EW'(k) + EW'(1) >= len_e) && (EW'(k) < c_e);
   end

   // match evaluation: candidate ending at the previous byte (A), and on the
   // last byte the candidate ending at the current byte (B)
   logic                       ms0, pre0;
   logic [ColW-1:0]            mp0;
   lsm_pkg::suffix_state_type  suf0, suf1, suf2, suf3;
   logic [7:0]                 start0;
   logic [EW-1:0]              pa, pb, start_e;
   logic                       bnd, word_b, hit_a, hit_b, ok_a, ms1;
   logic [ColW-1:0]            mp1;
   logic                       pre1, found;

   always_comb begin
      ms0    = first ? 1'b0 : ms_ff;
      mp0    = first ? '0 : mp_ff;
      pre0   = first ? 1'b1 : pre_ff;
      suf0   = first ? lsm_pkg::SUF_IDLE : suf_ff;
      start0 = first ? req_data.start_column : start_ff;

      start_e = EW'(start0);
      pa      = c_e - len_e;
      pb      = c_e + EW'(1) - len_e;
      bnd     = whole_word_ff || label_mode_ff;
      word_b  = lsm_pkg::is_word(req_data.text_byte);

      hit_a = !first && (len_e != '0) && !ms0 && (c_e <= EW'(LINE_MAX + 1)) &&
              (c_e >= len_e) && (pa >= start_e) && (&(~act_v | eqh_v)) &&
              !(bnd && (((pa != '0) && (|lefth_v)) || word_b));
      ok_a  = pre0 && (&(~rng_v | wordh_v));

      ms1  = ms0 || hit_a;
      mp1  = hit_a ? ColW'(pa) : mp0;
      suf1 = suf0;
      if (hit_a && label_mode_ff) begin
         suf1 = ok_a ? lsm_pkg::SUF_SCAN : lsm_pkg::SUF_FAIL;
      end

      suf2 = suf1;
      if (suf1 == lsm_pkg::SUF_SCAN) begin
         if (req_data.text_byte == lsm_pkg::COLON) begin
            suf2 = lsm_pkg::SUF_PASS;
         end else if (!word_b) begin
            suf2 = lsm_pkg::SUF_FAIL;
         end
      end

      pre1 = (c_e >= EW'(Depth) && !cell_st[Depth-1].word_hold) ? 1'b0 : pre0;

      // line end: an open suffix scan fails, and a match at the line edge has
      // no colon after it, so it can only pass outside label mode
      suf3  = (suf2 == lsm_pkg::SUF_SCAN) ? lsm_pkg::SUF_FAIL : suf2;
      hit_b = (len_e != '0) && !ms1 && (c_e <= EW'(LINE_MAX)) &&
              (c_e + EW'(1) >= len_e) && (pb >= start_e) && (&(~act_v | eqs_v)) &&
              !(bnd && (pb != '0) && (|lefts_v));

      found = 1'b0;
      if (hit_b) begin
         found = !label_mode_ff;
      end else begin
         found = ms1 && (!label_mode_ff || suf3 == lsm_pkg::SUF_PASS);
      end

      rsp_data_in.found        = found;
      rsp_data_in.match_column = found ? (hit_b ? 8'(pb) : 8'(mp1)) : 8'h00;
   end

   always_comb begin
      col_in   = col_ff;
      start_in = start_ff;
      ms_in    = ms_ff;
      mp_in    = mp_ff;
      pre_in   = pre_ff;
      suf_in   = suf_ff;
      if (req_accept) begin
         start_in = start0;
         ms_in    = ms1;
         mp_in    = mp1;
         pre_in   = pre1;
         suf_in   = suf2;
         if (last) begin
            col_in = '0;
         end else if (col_ff < ColW'(LINE_MAX + 2)) begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept && last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         start_ff     <= '0;
         ms_ff        <= 1'b0;
         mp_ff        <= '0;
         pre_ff       <= 1'b1;
         suf_ff       <= lsm_pkg::SUF_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         start_ff     <= start_in;
         ms_ff        <= ms_in;
         mp_ff        <= mp_in;
         pre_ff       <= pre_in;
         suf_ff       <= suf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a line end never overwrites a result that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.line_end) |-> !(rsp_valid_ff && rsp_stall))
      else $error("line end accepted while result held");

   a_col_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && last) |=> (col_ff == '0 && rsp_valid_ff))
      else $error("column count not restarted after line end");

   a_match_after_start: assert property (@(posedge clock) disable iff (reset)
      (ms_ff && !first) |-> (EW'(mp_ff) >= EW'(start_ff)))
      else $error("recorded match lies before start column");

   a_no_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.match_column == 8'h00))
      else $error("column reported without a match");

endmodule

@@ tb/sv/tb_line_substring_matcher.sv @@
// Self-checking testbench for the line substring matcher: stimulus, predictor and checks.
module tb_line_substring_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAT_MAX      = lsm_pkg::PATTERN_MAX_DEF;
   localparam int LN_MAX       = lsm_pkg::LINE_MAX_DEF;
   localparam int WIN          = PAT_MAX + 1;
   localparam int RANDOM_ITEMS = 1800;
   localparam logic [lsm_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 3'd5;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   lsm_pkg::req_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   lsm_pkg::rsp_type                rsp_data;
   logic                            csr_we    = 1'b0;
   logic [lsm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lsm_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   line_substring_matcher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // register copies
   logic [63:0] pat_lo    = '0;
   logic [63:0] pat_hi    = '0;
   logic [4:0]  pat_len   = 5'd1;
   bit          word_mode = 1'b0;
   bit          label_on  = 1'b0;

   // matcher state
   logic [7:0]                win_bytes [WIN];
   int                        line_col   = 0;
   int                        scan_from  = 0;
   bit                        hit_seen   = 1'b0;
   int                        hit_col    = 0;
   bit                        head_label = 1'b1;
   lsm_pkg::suffix_state_type tail_state = lsm_pkg::SUF_IDLE;

   lsm_pkg::req_type byte_pending [$];
   lsm_pkg::rsp_type match_expect [$];
   int      items_queued = 0;
   int      items_taken  = 0;
   int      results_seen = 0;
   int      errors       = 0;

   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;
   int send_left  = 0;
   int wait_left  = 0;
   int hold_left  = 0;
   int holds_done = 0;
   bit req_fired  = 1'b0;

   lsm_pkg::req_type taken_req;
   lsm_pkg::rsp_type taken_rsp;
   bit               taken_emits;
   lsm_pkg::rsp_type want;

   function automatic bit label_char(logic [7:0] b);
      bit digit, upper, lower;
      digit = b >= "0" && b <= "9";
      upper = b >= "A" && b <= "Z";
      lower = b >= "a" && b <= "z";
      return digit || upper || lower || b == ".";
   endfunction

   function automatic logic [7:0] pat_at(int i);
      if (i < 8) return pat_lo[8*i +: 8];
      if (i < 16) return pat_hi[8*(i-8) +: 8];
      return 8'h00;
   endfunction

   function automatic int eff_len();
      int n;
      n = pat_len;
      if (n == 0) n = 1;
      if (n > PAT_MAX) n = PAT_MAX;
      if (label_on && pat_at(n - 1) == lsm_pkg::COLON) n--;
      return n;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 7))
         0: return "a";
         1: return "b";
         2: return ".";
         3: return "1";
         4: return "Z";
         5: return " ";
         6: return lsm_pkg::COLON;
         default: return "-";
      endcase
   endfunction

   // judge the candidate that ends at column endpos
   task automatic try_hit(int endpos, bit has_right, logic [7:0] right);
      int n, p;
      bit ok;
      n = eff_len();
      if (n == 0 || hit_seen || endpos > LN_MAX || endpos + 1 < n) return;
      p = endpos + 1 - n;
      if (p < scan_from) return;
      for (int i = 0; i < n; i++) begin
         if (win_bytes[n-1-i] != pat_at(i)) return;
      end
      if (word_mode || label_on) begin
         if (p >= 1 && label_char(win_bytes[n])) return;
         if (has_right && label_char(right)) return;
      end
      hit_seen = 1'b1;
      hit_col  = p;
      if (label_on) begin
         ok = head_label;
         for (int k = n - 1; k < WIN && k <= endpos; k++) begin
            if (!label_char(win_bytes[k])) ok = 1'b0;
         end
         tail_state = (ok && has_right) ? lsm_pkg::SUF_SCAN : lsm_pkg::SUF_FAIL;
      end
   endtask

   task automatic scan_byte(input lsm_pkg::req_type r, output bit emits,
                            output lsm_pkg::rsp_type res);
      logic [7:0] b;
      int c;
      b = r.text_byte;
      emits = 1'b0;
      res = '0;
      if (line_col == 0) begin
         scan_from  = r.start_column;
         hit_seen   = 1'b0;
         hit_col    = 0;
         head_label = 1'b1;
         tail_state = lsm_pkg::SUF_IDLE;
         foreach (win_bytes[k]) win_bytes[k] = 8'h00;
      end
      c = line_col;
      if (c >= 1) try_hit(c - 1, 1'b1, b);
      if (tail_state == lsm_pkg::SUF_SCAN) begin
         if (b == lsm_pkg::COLON) tail_state = lsm_pkg::SUF_PASS;
         else if (!label_char(b)) tail_state = lsm_pkg::SUF_FAIL;
      end
      if (c >= WIN && !label_char(win_bytes[WIN-1])) head_label = 1'b0;
      for (int k = WIN - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = b;
      if (!r.line_end) begin
         if (line_col < LN_MAX + 2) line_col++;
      end else begin
         if (tail_state == lsm_pkg::SUF_SCAN) tail_state = lsm_pkg::SUF_FAIL;
         try_hit(c, 1'b0, 8'h00);
         res.found        = hit_seen && (!label_on || tail_state == lsm_pkg::SUF_PASS);
         res.match_column = res.found ? 8'(hit_col) : 8'h00;
         line_col = 0;
         emits    = 1'b1;
      end
   endtask

   // request side: bookkeeping at the rising edge, drive at the falling edge
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         taken_req = byte_pending.pop_front();
         scan_byte(taken_req, taken_emits, taken_rsp);
         if (taken_emits) match_expect.push_back(taken_rsp);
         items_taken++;
         req_fired = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (send_left > 0) begin
            req_valid <= 1'b0;
            send_left--;
         end else if (byte_pending.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= byte_pending[0];
            if (!send_quiet) send_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (match_expect.size() == 0) begin
            $error("result with no pending request: found %0d, match_column %0d",
                   rsp_data.found, rsp_data.match_column);
            errors++;
         end else begin
            want = match_expect.pop_front();
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_data.found);
               errors++;
            end
            if (rsp_data.match_column !== want.match_column) begin
               $error("match_column: expected %0d, got %0d",
                      want.match_column, rsp_data.match_column);
               errors++;
            end
         end
      end
   end

   // long hold-offs let a finished line back up behind the held result
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 30 : 100)) begin
         rsp_stall <= 1'b1;
         hold_left = 300;
         holds_done++;
      end else if (wait_left > 0) begin
         rsp_stall <= 1'b1;
         wait_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!recv_quiet) wait_left = pick_gap();
      end
   end

   task automatic set_reg(logic [lsm_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         lsm_pkg::CSR_PAT_LO:     pat_lo    = val;
         lsm_pkg::CSR_PAT_HI:     pat_hi    = val;
         lsm_pkg::CSR_PAT_LEN:    pat_len   = val[4:0];
         lsm_pkg::CSR_WHOLE_WORD: word_mode = val[0];
         lsm_pkg::CSR_LABEL_MODE: label_on  = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_all(logic [63:0] lo, logic [63:0] hi, logic [63:0] len,
                          logic [63:0] ww, logic [63:0] lbl);
      set_reg(lsm_pkg::CSR_PAT_LO, lo);
      set_reg(lsm_pkg::CSR_PAT_HI, hi);
      set_reg(lsm_pkg::CSR_PAT_LEN, len);
      set_reg(lsm_pkg::CSR_WHOLE_WORD, ww);
      set_reg(lsm_pkg::CSR_LABEL_MODE, lbl);
   endtask

   task automatic push_byte(logic [7:0] b, bit last, logic [7:0] sc);
      lsm_pkg::req_type item;
      item.text_byte    = b;
      item.line_end     = last;
      item.start_column = sc;
      byte_pending.push_back(item);
      items_queued++;
   endtask

   task automatic push_text(string s, logic [7:0] sc);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i], i == s.len() - 1, i == 0 ? sc : 8'($urandom));
      end
   endtask

   task automatic drain();
      while (items_taken != items_queued || match_expect.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_cfg(int ph);
      logic [127:0] pat;
      logic [63:0]  len_w, ww_w, lbl_w;
      int           n;
      bit           lbl;
      lbl = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
         0: n = 0;
         1: n = 16;
         2: n = $urandom_range(17, 31);
         3, 4: n = $urandom_range(5, 15);
         default: n = $urandom_range(1, 4);
      endcase
      for (int i = 0; i < 16; i++) begin
         pat[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : pick_char();
      end
      if (lbl && n >= 1 && n <= 16 && $urandom_range(0, 3) != 0)
         pat[8*(n-1) +: 8] = lsm_pkg::COLON;
      len_w = {$urandom, $urandom};
      ww_w  = {$urandom, $urandom};
      lbl_w = {$urandom, $urandom};
      len_w[4:0] = 5'(n);
      lbl_w[0]   = lbl;
      case (ph)
         0: begin
            pat = '1;
            len_w = 64'd16;
            ww_w = 64'd1;
            lbl_w = 64'd0;
         end
         1: begin
            len_w = 64'd0;
            lbl_w = 64'd0;
         end
         2: begin
            len_w = 64'd31;
            lbl_w = 64'd1;
         end
         default: ;
      endcase
      set_all(pat[63:0], pat[127:64], len_w, ww_w, lbl_w);
   endtask

   task automatic gen_line();
      logic [7:0] txt [$];
      logic [7:0] sc;
      int n, goal, pick, pos;
      n = eff_len();
      if (label_on && n > 0 && $urandom_range(0, 3) != 0) begin
         // label line: pattern at column 0, then a colon most of the time
         for (int i = 0; i < n; i++) txt.push_back(pat_at(i));
         txt.push_back(($urandom_range(0, 4) != 0) ? lsm_pkg::COLON : pick_char());
         repeat ($urandom_range(0, 6)) txt.push_back(pick_char());
         sc = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 2)) : 8'h00;
      end else begin
         goal = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 40);
         while (txt.size() < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               for (int i = 0; i < n; i++) txt.push_back(pat_at(i));
               if (n > 0 && pick < 6) begin
                  pos = $urandom_range(txt.size() - n, txt.size() - 1);
                  txt[pos] = txt[pos] ^ 8'($urandom_range(1, 255));
               end
            end else if (pick < 85) begin
               txt.push_back(pick_char());
            end else begin
               txt.push_back(8'($urandom_range(0, 255)));
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) sc = 8'h00;
         else if (pick < 85) sc = 8'($urandom_range(0, txt.size()));
         else sc = 8'($urandom);
      end
      foreach (txt[i]) begin
         push_byte(txt[i], i == txt.size() - 1, i == 0 ? sc : 8'($urandom));
      end
   endtask

   initial begin
      int base;
      int ph;
      int phase_start;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset pattern is a single zero byte
      push_byte(8'h00, 1'b1, 8'h00);
      push_byte(8'hFF, 1'b0, 8'hFF);
      push_byte(8'h00, 1'b1, 8'h00);
      drain();

      // whole-word boundaries
      set_reg(CSR_SPARE, {$urandom, $urandom});
      set_all(64'h6261, 64'h0, 64'd2, 64'd1, 64'd0);
      push_text("ab", 8'd0);
      push_text("xab ab", 8'd1);
      push_text("ab.", 8'd0);
      drain();

      // label rules: closed label, missing colon, non-label prefix
      set_all(64'h3A626C, 64'h0, 64'd3, 64'd0, 64'd1);
      push_text("lb:", 8'd0);
      push_text("lb", 8'd0);
      push_text("x lb:", 8'd0);
      drain();

      // pattern that is only a colon leaves nothing to match in label mode
      set_all(64'h3A, 64'h0, 64'd1, 64'd0, 64'd1);
      push_text(":", 8'd0);
      drain();

      base = items_queued;
      ph = 0;
      while (items_queued < base + RANDOM_ITEMS) begin
         send_quiet = (ph % 4 == 1);
         recv_quiet = (ph % 4 == 2);
         random_cfg(ph);
         phase_start = items_queued;
         while (items_queued < phase_start + 150) gen_line();
         drain();
         ph++;
      end

      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
